// ===== rtl/core/vhtre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhtre_pkg
// Shared types, codes and rate tables of the VHT RX rate estimator.
// ----------------------------------------------------------------------------
package vhtre_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SUPPORT   = 2'd0;
  localparam logic [1:0] REG_RX_MAP    = 2'd1;
  localparam logic [1:0] REG_WIDTH_SET = 2'd2;
  localparam logic [1:0] REG_SGI       = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNSUP     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_NO_RATE   = 2'd3;

  localparam int NUM_MCS   = 10;
  localparam int RATE_W    = 30;
  localparam int DRATE_W   = 33;
  localparam logic [1:0] MCS_UNSUP = 2'd3;

  // Minimum RSSI per MCS at 20 MHz; each wider step adds 3 dB
  localparam logic signed [7:0] BASE_RSSI [NUM_MCS] = '{
    -8'sd82, -8'sd79, -8'sd77, -8'sd74, -8'sd70,
    -8'sd66, -8'sd65, -8'sd64, -8'sd59, -8'sd57
  };

  // Single-stream rate, long guard interval, indexed [width][mcs]
  localparam logic [RATE_W-1:0] RATE_LGI [4][NUM_MCS] = '{
    '{30'd6500000, 30'd13000000, 30'd19500000, 30'd26000000, 30'd39000000,
      30'd52000000, 30'd58500000, 30'd65000000, 30'd78000000, 30'd86666000},
    '{30'd13500000, 30'd27000000, 30'd40500000, 30'd54000000, 30'd81000000,
      30'd108000000, 30'd121500000, 30'd135000000, 30'd162000000, 30'd180000000},
    '{30'd29250000, 30'd58500000, 30'd87750000, 30'd117000000, 30'd175500000,
      30'd234000000, 30'd263250000, 30'd292500000, 30'd351000000, 30'd390000000},
    '{30'd58500000, 30'd117000000, 30'd175500000, 30'd234000000, 30'd351000000,
      30'd468000000, 30'd526500000, 30'd585000000, 30'd702000000, 30'd780000000}
  };

  // Short guard interval: floor(rate / 9) * 10
  localparam logic [RATE_W-1:0] RATE_SGI [4][NUM_MCS] = '{
    '{30'd7222220, 30'd14444440, 30'd21666660, 30'd28888880, 30'd43333330,
      30'd57777770, 30'd65000000, 30'd72222220, 30'd86666660, 30'd96295550},
    '{30'd15000000, 30'd30000000, 30'd45000000, 30'd60000000, 30'd90000000,
      30'd120000000, 30'd135000000, 30'd150000000, 30'd180000000, 30'd200000000},
    '{30'd32500000, 30'd65000000, 30'd97500000, 30'd130000000, 30'd195000000,
      30'd260000000, 30'd292500000, 30'd325000000, 30'd390000000, 30'd433333330},
    '{30'd65000000, 30'd130000000, 30'd195000000, 30'd260000000, 30'd390000000,
      30'd520000000, 30'd585000000, 30'd650000000, 30'd780000000, 30'd866666660}
  };

  typedef struct packed {
    logic [1:0]  support;
    logic [15:0] rx_map;
    logic [1:0]  width_set;
    logic [3:0]  sgi;
  } cfg_t;

  typedef struct packed {
    logic              elements_present;
    logic [15:0]       peer_tx_mcs_map;
    logic [3:0]        peer_sgi_flags;
    logic [7:0]        vht_op_width;
    logic              seg1_nonzero;
    logic [1:0]        ht_sec_offset;
    logic              ht_any_width;
    logic signed [7:0] rssi_dbm;
  } item_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic              early;   // status decided, no search
    logic [1:0]        status;
    logic [3:0]        nss;     // 1..8
    logic [3:0]        top;     // 7..9
    logic signed [7:0] rssi;
    logic [3:0]        wen;     // allowed widths, bit = 20/40/80/160
    logic [3:0]        sgi;     // common short GI per width
  } job_t;

endpackage

// ===== rtl/core/vhtre_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhtre_front
// Classify one peer beat: early status checks, stream search, width masks.
// ----------------------------------------------------------------------------
module vhtre_front (
  input  vhtre_pkg::cfg_t  cfg,
  input  vhtre_pkg::item_t item,
  output vhtre_pkg::job_t  job
);

  logic       found;
  logic [2:0] k_sel;
  logic [1:0] min_code;
  logic [1:0] rx_c;
  logic [1:0] tx_c;
  logic       en160;

  // Highest common stream wins: ascending scan, later hits overwrite
  always_comb begin
    found    = 1'b0;
    k_sel    = '0;
    min_code = '0;
    rx_c     = '0;
    tx_c     = '0;
    for (int k = 0; k < 8; k++) begin
      rx_c = cfg.rx_map[2*k +: 2];
      tx_c = item.peer_tx_mcs_map[2*k +: 2];
      if (rx_c != vhtre_pkg::MCS_UNSUP && tx_c != vhtre_pkg::MCS_UNSUP) begin
        found    = 1'b1;
        k_sel    = 3'(k);
        min_code = (rx_c < tx_c) ? rx_c : tx_c;
      end
    end
  end

  assign en160 = (cfg.width_set == 2'd1 || cfg.width_set == 2'd2) &&
                 (item.vht_op_width == 8'd2 || item.vht_op_width == 8'd3 ||
                  (item.vht_op_width == 8'd1 && item.seg1_nonzero));

  always_comb begin
    job.early  = 1'b0;
    job.status = vhtre_pkg::ST_OK;
    job.nss    = {1'b0, k_sel} + 4'd1;
    job.top    = 4'd7 + {2'b00, min_code};
    job.rssi   = item.rssi_dbm;
    job.wen    = {en160,
                  item.vht_op_width == 8'd1,
                  item.ht_any_width &&
                    (item.ht_sec_offset == 2'd1 || item.ht_sec_offset == 2'd3),
                  1'b1};
    job.sgi    = cfg.sgi & item.peer_sgi_flags;
    priority if (cfg.support != 2'b11) begin
      job.early  = 1'b1;
      job.status = vhtre_pkg::ST_UNSUP;
    end else if (!item.elements_present) begin
      job.early  = 1'b1;
      job.status = vhtre_pkg::ST_UNSUP;
    end else if (item.vht_op_width > 8'd3) begin
      job.early  = 1'b1;
      job.status = vhtre_pkg::ST_MALFORMED;
    end else if (!found) begin
      job.early  = 1'b1;
      job.status = vhtre_pkg::ST_MALFORMED;
    end else begin
      // Well-formed peer: hand it to the search
      job.early  = 1'b0;
    end
  end

endmodule

// ===== rtl/core/vhtre_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhtre_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module vhtre_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vhtre_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output vhtre_pkg::job_t head
);

  vhtre_pkg::job_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/vhtre_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhtre_back
// Width/MCS search sequencer, rate scaling and output register.
// ----------------------------------------------------------------------------
module vhtre_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  vhtre_pkg::job_t                  q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [vhtre_pkg::DRATE_W-1:0]    out_rate_bps
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]                        st_r, st_nxt;
  vhtre_pkg::job_t                   job_r;
  logic [1:0]                        w_r, w_nxt;
  logic [vhtre_pkg::RATE_W-1:0]      rate_r;
  logic [1:0]                        res_status_r, res_status_nxt;
  logic [vhtre_pkg::DRATE_W-1:0]     res_rate_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r;
  logic [vhtre_pkg::DRATE_W-1:0]     out_rate_r;

  logic                              hit;
  logic [3:0]                        mcs;
  logic signed [8:0]                 rssi_x;
  logic signed [8:0]                 base_x;
  logic signed [8:0]                 th;
  logic [8:0]                        step;
  logic [vhtre_pkg::RATE_W-1:0]      rate_sel;
  logic [33:0]                       prod;
  logic                              out_free;

  // Top MCS meeting RSSI at the current width; ascending scan, last hit wins
  always_comb begin
    hit    = 1'b0;
    mcs    = '0;
    rssi_x = 9'(job_r.rssi);
    step   = {6'b0, w_r, 1'b0} + {7'b0, w_r};
    base_x = '0;
    th     = '0;
    for (int m = 0; m < vhtre_pkg::NUM_MCS; m++) begin
      base_x = 9'(vhtre_pkg::BASE_RSSI[m]);
      th     = base_x + $signed(step);
      if (4'(m) <= job_r.top && rssi_x >= th) begin
        hit = 1'b1;
        mcs = 4'(m);
      end
    end
  end

  assign rate_sel = job_r.sgi[w_r] ? vhtre_pkg::RATE_SGI[w_r][mcs]
                                   : vhtre_pkg::RATE_LGI[w_r][mcs];
  assign prod     = {4'b0, rate_r} * {30'b0, job_r.nss};
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (st_r == B_IDLE) && !q_empty;

  always_comb begin
    st_nxt         = st_r;
    w_nxt          = w_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          w_nxt          = 2'd3;
          res_status_nxt = q_head.status;
          st_nxt         = q_head.early ? B_DONE : B_SCAN;
        end
      end
      B_SCAN: begin
        if (job_r.wen[w_r] && hit) begin
          res_status_nxt = vhtre_pkg::ST_OK;
          st_nxt         = B_MUL;
        end else if (w_r == 2'd0) begin
          res_status_nxt = vhtre_pkg::ST_NO_RATE;
          st_nxt         = B_DONE;
        end else begin
          w_nxt = w_r - 2'd1;
        end
      end
      B_MUL: begin
        st_nxt = B_DONE;
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    res_status_r <= res_status_nxt;
    if (q_pop) begin
      job_r      <= q_head;
      res_rate_r <= '0;
    end
    if (st_r == B_SCAN) begin
      rate_r <= rate_sel;
    end
    if (st_r == B_MUL) begin
      res_rate_r <= prod[vhtre_pkg::DRATE_W-1:0];
    end
    if (st_r == B_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_rate_r   <= res_rate_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_rate_bps = out_rate_r;

endmodule

// ===== rtl/core/vht_rx_rate_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vht_rx_rate_estimator
// Estimate the VHT receive data rate of a peer from its capabilities and RSSI.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake           | Beat contents
//   --------+---------------------+---------------------------------------------
//   in_     | in_valid/in_ready   | peer capability/operation fields, RSSI
//   out_    | out_valid/out_ready | status, rate (bit/s)
//   cfg_    | cfg_we              | cfg_idx selects register, cfg_wdata value
//
// An item passes from acceptance to a valid result through the back-end
// search sequencer: a pop step, one step per tried channel width (160, 80,
// 40, 20 MHz), a multiply step and an output step that waits out output
// stalls. Early-status items skip the width search and the multiply step.
// A two-entry job queue lets the front accept while the back is busy.
// Reset (rst_n low, synchronous) empties the queue and output register and
// loads the configuration registers with their defaults.
// Output stalls hold the result register; the queue then fills and drops
// in_ready.
// ----------------------------------------------------------------------------
module vht_rx_rate_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [15:0]                   cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_elements_present,
  input  logic [15:0]                   in_peer_tx_mcs_map,
  input  logic [3:0]                    in_peer_sgi_flags,
  input  logic [7:0]                    in_vht_op_width,
  input  logic                          in_seg1_nonzero,
  input  logic [1:0]                    in_ht_sec_offset,
  input  logic                          in_ht_any_width,
  input  logic signed [7:0]             in_rssi_dbm,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [vhtre_pkg::DRATE_W-1:0] out_rate_bps
);

  vhtre_pkg::cfg_t  cfg_r;
  vhtre_pkg::item_t item;
  vhtre_pkg::job_t  front_job;
  vhtre_pkg::job_t  q_head;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             push;

  // Configuration registers, written by the user only while idle; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.support   <= 2'd0;
      cfg_r.rx_map    <= 16'hFFFF;
      cfg_r.width_set <= 2'd0;
      cfg_r.sgi       <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vhtre_pkg::REG_SUPPORT:   cfg_r.support   <= cfg_wdata[1:0];
        vhtre_pkg::REG_RX_MAP:    cfg_r.rx_map    <= cfg_wdata;
        vhtre_pkg::REG_WIDTH_SET: cfg_r.width_set <= cfg_wdata[1:0];
        vhtre_pkg::REG_SGI:       cfg_r.sgi       <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Gather the input beat
  always_comb begin
    item.elements_present = in_elements_present;
    item.peer_tx_mcs_map  = in_peer_tx_mcs_map;
    item.peer_sgi_flags   = in_peer_sgi_flags;
    item.vht_op_width     = in_vht_op_width;
    item.seg1_nonzero     = in_seg1_nonzero;
    item.ht_sec_offset    = in_ht_sec_offset;
    item.ht_any_width     = in_ht_any_width;
    item.rssi_dbm         = in_rssi_dbm;
  end

  // Front: classify and push while the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  vhtre_front u_front (
    .cfg  (cfg_r),
    .item (item),
    .job  (front_job)
  );

  vhtre_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: width/MCS search, scale by streams, hold result until taken
  vhtre_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_rate_bps (out_rate_bps)
  );

  // A failed estimate reports no rate
  a_rate_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vhtre_pkg::ST_OK |-> out_rate_bps == '0)
    else $error("nonzero rate with error status");

  // A successful estimate always has a rate
  a_rate_nonzero_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vhtre_pkg::ST_OK |-> out_rate_bps != '0)
    else $error("zero rate with ok status");

  // Nothing is presented right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== dv/vht_rx_rate_estimator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vht_rx_rate_estimator_test
// Self-checking bench for the VHT RX rate estimator: a directed table of peer
// records (reset defaults, unsupported, malformed, RSSI thresholds, top rate), then
// randomized phases under varying register settings, all scored in order
// against typed rows or the predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module vht_rx_rate_estimator_test;
  import vhtre_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 8;
  localparam int N_PHASES   = 9;
  localparam int PHASE_LEN  = 50;
  localparam int SETTLE     = 12;      // drain margin after the last result
  localparam int LIMIT      = 600000;  // cycle ceiling for the whole run
  localparam int MAX_REPORT = 10;

  // Minimum RSSI per MCS at 20 MHz, own copy for prediction
  localparam int SENS_DBM [10] = '{-82, -79, -77, -74, -70, -66, -65, -64, -59, -57};

  // Single-stream long-GI rate, [width][mcs], width 0 = 20 MHz .. 3 = 160 MHz
  localparam longint unsigned LGI_BPS [4][10] = '{
    '{64'd6500000, 64'd13000000, 64'd19500000, 64'd26000000, 64'd39000000,
      64'd52000000, 64'd58500000, 64'd65000000, 64'd78000000, 64'd86666000},
    '{64'd13500000, 64'd27000000, 64'd40500000, 64'd54000000, 64'd81000000,
      64'd108000000, 64'd121500000, 64'd135000000, 64'd162000000, 64'd180000000},
    '{64'd29250000, 64'd58500000, 64'd87750000, 64'd117000000, 64'd175500000,
      64'd234000000, 64'd263250000, 64'd292500000, 64'd351000000, 64'd390000000},
    '{64'd58500000, 64'd117000000, 64'd175500000, 64'd234000000, 64'd351000000,
      64'd468000000, 64'd526500000, 64'd585000000, 64'd702000000, 64'd780000000}
  };

  typedef struct {
    logic [1:0]         status;
    logic [DRATE_W-1:0] rate;
  } rate_est_t;

  typedef struct {
    cfg_t      cfg;
    item_t     peer;
    bit        typed;   // expected result written into the row
    rate_est_t want;
  } peer_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_elements_present;
  logic [15:0]        in_peer_tx_mcs_map;
  logic [3:0]         in_peer_sgi_flags;
  logic [7:0]         in_vht_op_width;
  logic               in_seg1_nonzero;
  logic [1:0]         in_ht_sec_offset;
  logic               in_ht_any_width;
  logic signed [7:0]  in_rssi_dbm;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [DRATE_W-1:0] out_rate_bps;

  vht_rx_rate_estimator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_elements_present (in_elements_present),
    .in_peer_tx_mcs_map  (in_peer_tx_mcs_map),
    .in_peer_sgi_flags   (in_peer_sgi_flags),
    .in_vht_op_width     (in_vht_op_width),
    .in_seg1_nonzero     (in_seg1_nonzero),
    .in_ht_sec_offset    (in_ht_sec_offset),
    .in_ht_any_width     (in_ht_any_width),
    .in_rssi_dbm         (in_rssi_dbm),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_rate_bps        (out_rate_bps)
  );

  always #(CLK_HALF) clk = ~clk;

  // Scoreboard state
  rate_est_t  expected_rates [$];
  peer_row_t  peer_table [$];
  cfg_t       cur_cfg;
  int         mismatches   = 0;
  int         results_seen = 0;
  int         rates_ok     = 0;
  int         items_sent   = 0;
  int         cfg_settings = 0;
  int         cycle_count  = 0;
  int         ready_hold   = 0;
  bit         tx_steady    = 1'b0;  // no gaps on the input side
  bit         rx_steady    = 1'b0;  // no stalls on the result side

  // --------------------------------------------------------------------------
  // Rate predictor: status first (support, elements, width byte, streams),
  // then the width ladder 160/80/40/20 with a top-down MCS scan per width.
  // --------------------------------------------------------------------------
  function automatic rate_est_t estimate_rate(cfg_t c, item_t p);
    rate_est_t        r;
    int               nss;
    int               top;
    int               rssi;
    logic [1:0]       rxc;
    logic [1:0]       txc;
    logic [3:0]       both_sgi;
    logic [3:0]       wen;
    longint unsigned  bps;
    r.status = ST_OK;
    r.rate   = '0;
    if (c.support != 2'b11 || !p.elements_present) begin
      r.status = ST_UNSUP;
      return r;
    end
    if (p.vht_op_width > 8'd3) begin
      r.status = ST_MALFORMED;
      return r;
    end
    // Highest stream count that both maps carry
    nss = 0;
    top = 7;
    for (int k = 7; k >= 0; k--) begin
      rxc = c.rx_map[2*k +: 2];
      txc = p.peer_tx_mcs_map[2*k +: 2];
      if (nss == 0 && rxc != MCS_UNSUP && txc != MCS_UNSUP) begin
        top = 7 + ((rxc < txc) ? int'(rxc) : int'(txc));
        nss = k + 1;
      end
    end
    if (nss == 0) begin
      r.status = ST_MALFORMED;
      return r;
    end
    wen[3] = (c.width_set == 2'd1 || c.width_set == 2'd2) &&
             (p.vht_op_width == 8'd2 || p.vht_op_width == 8'd3 ||
              (p.vht_op_width == 8'd1 && p.seg1_nonzero));
    wen[2] = (p.vht_op_width == 8'd1);
    wen[1] = p.ht_any_width && (p.ht_sec_offset == 2'd1 || p.ht_sec_offset == 2'd3);
    wen[0] = 1'b1;
    both_sgi = c.sgi & p.peer_sgi_flags;
    rssi = int'($signed(p.rssi_dbm));
    for (int w = 3; w >= 0; w--) begin
      if (wen[w]) begin
        for (int m = top; m >= 0; m--) begin
          if (rssi >= SENS_DBM[m] + 3 * w) begin
            bps = LGI_BPS[w][m];
            if (both_sgi[w]) bps = bps / 9 * 10;
            r.rate = DRATE_W'(bps * longint'(nss));
            return r;
          end
        end
      end
    end
    r.status = ST_NO_RATE;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cfg_t make_cfg(logic [1:0] sup, logic [15:0] map,
                                    logic [1:0] ws, logic [3:0] sgi);
    cfg_t c;
    c.support   = sup;
    c.rx_map    = map;
    c.width_set = ws;
    c.sgi       = sgi;
    return c;
  endfunction

  function automatic item_t make_peer(bit pres, logic [15:0] map, logic [3:0] psgi,
                                      logic [7:0] opw, bit seg1, logic [1:0] off,
                                      bit htw, int rssi);
    item_t p;
    p.elements_present = pres;
    p.peer_tx_mcs_map  = map;
    p.peer_sgi_flags   = psgi;
    p.vht_op_width     = opw;
    p.seg1_nonzero     = seg1;
    p.ht_sec_offset    = off;
    p.ht_any_width     = htw;
    p.rssi_dbm         = 8'(rssi);
    return p;
  endfunction

  // Append one table row; typed rows carry their own status and rate
  task automatic add_row(cfg_t c, item_t p, bit typed, logic [1:0] st,
                         logic [DRATE_W-1:0] rate);
    peer_row_t row;
    row.cfg         = c;
    row.peer        = p;
    row.typed       = typed;
    row.want.status = st;
    row.want.rate   = rate;
    peer_table.push_back(row);
  endtask

  // Mostly a map with a run of random low stream codes, unsupported ones above
  function automatic logic [15:0] rand_mcs_map();
    logic [15:0] map;
    int          nlow;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    nlow = $urandom_range(0, 8);
    map  = 16'hFFFF;
    for (int k = 0; k < 8; k++)
      if (k < nlow) map[2*k +: 2] = 2'($urandom_range(0, 3));
    return map;
  endfunction

  function automatic cfg_t rand_cfg(int phase);
    case (phase)
      0:       return make_cfg(2'b11, 16'h0000, 2'd0, 4'h0);
      1:       return make_cfg(2'b11, 16'hAAAA, 2'd2, 4'hF);
      2:       return make_cfg(2'b11, 16'hFFFF, 2'd3, 4'hF);
      3:       return make_cfg(2'($urandom_range(0, 3)), rand_mcs_map(),
                               2'($urandom), 4'($urandom));
      default: return make_cfg(($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b11,
                               rand_mcs_map(), 2'($urandom), 4'($urandom));
    endcase
  endfunction

  // Mostly well-formed peers with RSSI around the MCS thresholds; rest is noise
  function automatic item_t rand_peer();
    item_t p;
    if ($urandom_range(0, 99) < 80) begin
      p = make_peer($urandom_range(0, 19) != 0, rand_mcs_map(), 4'($urandom),
                    8'($urandom_range(0, 3)), 1'($urandom), 2'($urandom),
                    1'($urandom),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) - 128
                                                : $urandom_range(0, 60) - 95);
    end else begin
      p = make_peer(1'($urandom), 16'($urandom), 4'($urandom), 8'($urandom),
                    1'($urandom), 2'($urandom), 1'($urandom),
                    $urandom_range(0, 255) - 128);
    end
    return p;
  endfunction

  // Input gaps: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat, hold it until accepted, then log its expected result
  task automatic send_peer(item_t p, rate_est_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_elements_present <= p.elements_present;
    in_peer_tx_mcs_map  <= p.peer_tx_mcs_map;
    in_peer_sgi_flags   <= p.peer_sgi_flags;
    in_vht_op_width     <= p.vht_op_width;
    in_seg1_nonzero     <= p.seg1_nonzero;
    in_ht_sec_offset    <= p.ht_sec_offset;
    in_ht_any_width     <= p.ht_any_width;
    in_rssi_dbm         <= p.rssi_dbm;
    in_valid            <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rates.push_back(want);
    items_sent++;
  endtask

  // Drain all pending results, settle, then load all four registers.
  // Narrow registers get random junk above their width.
  task automatic load_config(cfg_t c);
    logic [15:0] junk;
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    junk = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SUPPORT;
    cfg_wdata <= {junk[15:2], c.support};
    @(posedge clk);
    cfg_idx   <= REG_RX_MAP;
    cfg_wdata <= c.rx_map;
    @(posedge clk);
    cfg_idx   <= REG_WIDTH_SET;
    cfg_wdata <= {junk[13:0], c.width_set};
    @(posedge clk);
    cfg_idx   <= REG_SGI;
    cfg_wdata <= {junk[11:0], c.sgi};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cfg = c;
    cfg_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: score every beat, then pick the next ready level
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rate_est_t want;
    int        r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_status == ST_OK) rates_ok++;
        if (expected_rates.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("unexpected result: status %0d rate %0d", out_status, out_rate_bps);
        end else begin
          want = expected_rates.pop_front();
          if (out_status !== want.status || out_rate_bps !== want.rate) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
              $display("result %0d mismatch: expected status %0d rate %0d, got %0d rate %0d",
                       results_seen, want.status, want.rate, out_status, out_rate_bps);
          end
        end
      end
      // Hold ready for the current stretch, then draw a new one
      if (ready_hold != 0) begin
        ready_hold--;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready  <= 1'b1;
          ready_hold = $urandom_range(0, 6);
        end else if (r < 92) begin
          out_ready  <= 1'b0;
          ready_hold = $urandom_range(0, 3);
        end else begin
          out_ready  <= 1'b0;
          ready_hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_rates.size());
      $display("vht_rx_rate_estimator_test: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t      c_rst;
    cfg_t      c_ht;
    cfg_t      c_vht;
    cfg_t      c_low;
    cfg_t      c_top;
    cfg_t      c_mid;
    rate_est_t want;
    item_t     p;

    // Drive every input to a known value before the first edge
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_SUPPORT;
    cfg_wdata           <= '0;
    in_valid            <= 1'b0;
    in_elements_present <= 1'b0;
    in_peer_tx_mcs_map  <= '0;
    in_peer_sgi_flags   <= '0;
    in_vht_op_width     <= '0;
    in_seg1_nonzero     <= 1'b0;
    in_ht_sec_offset    <= '0;
    in_ht_any_width     <= 1'b0;
    in_rssi_dbm         <= '0;
    out_ready           <= 1'b0;

    c_rst = make_cfg(2'b00, 16'hFFFF, 2'd0, 4'h0);
    c_ht  = make_cfg(2'b01, 16'h0000, 2'd1, 4'hF);
    c_vht = make_cfg(2'b10, 16'h0000, 2'd1, 4'hF);
    c_low = make_cfg(2'b11, 16'h0000, 2'd1, 4'hF);
    c_top = make_cfg(2'b11, 16'hAAAA, 2'd2, 4'hF);
    c_mid = make_cfg(2'b11, 16'h5555, 2'd3, 4'h5);
    cur_cfg = c_rst;

    // Reset defaults: we support neither HT nor VHT
    add_row(c_rst, make_peer(1, 16'h0000, 4'hF, 8'd2, 1, 2'd1, 1, 127), 1, ST_UNSUP, 0);
    // Only one of the two support bits
    add_row(c_ht,  make_peer(1, 16'h0000, 4'hF, 8'd0, 0, 2'd0, 0, 127), 1, ST_UNSUP, 0);
    add_row(c_vht, make_peer(1, 16'h0000, 4'hF, 8'd0, 0, 2'd0, 0, 127), 1, ST_UNSUP, 0);
    // Elements missing beats a malformed width byte
    add_row(c_low, make_peer(0, 16'h0000, 4'h0, 8'hFF, 0, 2'd0, 0, 0), 1, ST_UNSUP, 0);
    // Malformed width byte, both extremes above 3
    add_row(c_low, make_peer(1, 16'h0000, 4'h0, 8'hFF, 1, 2'd3, 1, 0), 1, ST_MALFORMED, 0);
    add_row(c_low, make_peer(1, 16'h0000, 4'h0, 8'd4, 0, 2'd0, 0, 0), 1, ST_MALFORMED, 0);
    // No common stream
    add_row(c_low, make_peer(1, 16'hFFFF, 4'hF, 8'd0, 0, 2'd0, 0, 0), 1, ST_MALFORMED, 0);
    // One stream, 20 MHz only, strongest RSSI: MCS 7 long GI
    add_row(c_low, make_peer(1, 16'hFFFC, 4'h0, 8'd0, 0, 2'd0, 0, 127), 1, ST_OK,
            33'd65000000);
    // Weakest RSSI everywhere: no usable rate
    add_row(c_low, make_peer(1, 16'h0000, 4'hF, 8'd3, 1, 2'd1, 1, -128), 1, ST_NO_RATE, 0);
    add_row(c_low, make_peer(1, 16'h0000, 4'hF, 8'd2, 0, 2'd3, 1, 127), 0, ST_OK, 0);
    // Eight streams, MCS 9, 160 MHz, short GI: the largest rate
    add_row(c_top, make_peer(1, 16'hAAAA, 4'hF, 8'd3, 0, 2'd0, 0, 127), 1, ST_OK,
            33'd6933333280);
    // 160 MHz through segment 1 versus plain 80 MHz, at the MCS 9 threshold
    add_row(c_top, make_peer(1, 16'hAAAA, 4'h4, 8'd1, 1, 2'd0, 0, -51), 0, ST_OK, 0);
    add_row(c_top, make_peer(1, 16'hAAAA, 4'h4, 8'd1, 0, 2'd0, 0, -51), 0, ST_OK, 0);
    add_row(c_top, make_peer(1, 16'hAAAA, 4'h4, 8'd1, 0, 2'd0, 0, -52), 0, ST_OK, 0);
    // 40 MHz above, below, and an offset that does not count
    add_row(c_top, make_peer(1, 16'hFFFA, 4'h2, 8'd0, 0, 2'd1, 1, -54), 0, ST_OK, 0);
    add_row(c_top, make_peer(1, 16'hFFFA, 4'h2, 8'd0, 0, 2'd3, 1, -76), 0, ST_OK, 0);
    add_row(c_top, make_peer(1, 16'hFFFA, 4'h2, 8'd0, 0, 2'd2, 1, -76), 0, ST_OK, 0);
    // 20 MHz MCS 0 exactly at its threshold, and one dB under it
    add_row(c_top, make_peer(1, 16'hFFFE, 4'h0, 8'd0, 0, 2'd0, 0, -82), 1, ST_OK,
            33'd6500000);
    add_row(c_top, make_peer(1, 16'hFFFE, 4'h0, 8'd0, 0, 2'd0, 0, -83), 1, ST_NO_RATE, 0);
    // Mixed codes: highest common stream sets the top MCS
    add_row(c_top, make_peer(1, 16'hFFF1, 4'hF, 8'd0, 0, 2'd0, 0, -60), 0, ST_OK, 0);
    // Width set 3 blocks 160 MHz; single-side short GI
    add_row(c_mid, make_peer(1, 16'h5555, 4'hA, 8'd2, 1, 2'd1, 1, -40), 0, ST_OK, 0);
    add_row(c_mid, make_peer(1, 16'h7FFF, 4'hF, 8'd1, 1, 2'd0, 0, -70), 0, ST_OK, 0);
    add_row(c_mid, make_peer(1, 16'hD555, 4'h1, 8'd0, 0, 2'd0, 0, -64), 0, ST_OK, 0);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; reload registers wherever a row changes them
    foreach (peer_table[i]) begin
      if (peer_table[i].cfg != cur_cfg) load_config(peer_table[i].cfg);
      want = peer_table[i].typed ? peer_table[i].want
                                 : estimate_rate(cur_cfg, peer_table[i].peer);
      send_peer(peer_table[i].peer, want);
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_config(rand_cfg(ph));
      tx_steady = (ph == 1 || ph == 5);
      rx_steady = (ph == 1 || ph == 6);
      for (int n = 0; n < PHASE_LEN; n++) begin
        p = rand_peer();
        send_peer(p, estimate_rate(cur_cfg, p));
      end
    end

    // Drop valid, wait out every pending result, then settle
    in_valid <= 1'b0;
    tx_steady = 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d peer records over %0d register settings", items_sent, cfg_settings);
    $display("scored %0d results, %0d with a rate, %0d mismatches", results_seen, rates_ok,
             mismatches);
    if (mismatches == 0 && expected_rates.size() == 0) begin
      $display("vht_rx_rate_estimator_test: PASS");
    end else begin
      $display("vht_rx_rate_estimator_test: FAIL");
    end
    $finish;
  end

endmodule
